FILE: rtl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants for the longest increasing subsequence block.
// ----------------------------------------------------------------------------
package lis_pkg;

   localparam int LENGTH_BITS   = 11;
   localparam int RSP_DATA_BITS = 16;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - LENGTH_BITS - 1;

endpackage

FILE: rtl/longest_increasing_subsequence.sv
// ----------------------------------------------------------------------------
// longest_increasing_subsequence
// Streams values in and reports, per word, the length of the longest strictly
// increasing subsequence seen so far.
//
// req channel: one value per word in req_tdata, req_tuser set empties the
// table by clearing the length and overflow flag before the value is used.
// rsp channel: exactly one word per request, holding the current length and
// a sticky overflow flag (set when an append was dropped on a full table).
// Tails are kept sorted in a single-port-read, single-port-write RAM with a
// registered read. A binary search issues one read per cycle: an accepted
// word issues the first read (or goes straight to the update on an empty
// table), each probe narrows the range and issues the next read, then the
// update may write a tail, registers the result and returns to idle for the next word.
// The result sits in an output register; a new word is accepted while it
// waits. If the receiver stalls with a result still pending, the block holds
// its next result and accepts nothing until the register frees.
// Reset clears the length, the overflow flag and the handshake state; the
// RAM is not cleared, entries are only read below the current length.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence #(
   parameter  int TABLE_DEPTH   = 1024,
   parameter  int VALUE_BITS    = 30,
   localparam int REQ_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_DATA_BITS-1:0]          req_tdata,  // sample_value
   input  logic                              req_tuser,  // start_sequence
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lis_pkg::RSP_DATA_BITS-1:0] rsp_tdata   // lis_length, overflow
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_UPDATE,
      ST_HOLD
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [LW-1:0]          len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic [LW-1:0]          lo_ff, lo_in;
   logic [LW-1:0]          hi_ff, hi_in;
   logic [LW-1:0]          mid_ff, mid_in;
   logic                   eq_ff, eq_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [lis_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [VALUE_BITS-1:0]  tail_mem_ff [TABLE_DEPTH];
   logic [VALUE_BITS-1:0]  rd_data_ff;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;

   logic                   accept;
   logic                   slot_free;
   logic [LW-1:0]          start_len;
   logic                   gt;
   logic [LW-1:0]          lo_n, hi_n, mid_n;
   logic [LW-1:0]          upd_len;
   logic                   upd_ovf;

   function automatic logic [lis_pkg::RSP_DATA_BITS-1:0] pack_rsp(
      input logic [LW-1:0] len,
      input logic          ovf
   );
      logic [LW+lis_pkg::LENGTH_BITS-1:0] ext;
      ext = {{lis_pkg::LENGTH_BITS{1'b0}}, len};
      return {{lis_pkg::RSP_PAD_BITS{1'b0}}, ovf, ext[lis_pkg::LENGTH_BITS-1:0]};
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign start_len  = req_tuser ? '0 : len_ff;

   assign gt    = rd_data_ff > value_ff;
   assign lo_n  = gt ? lo_ff : mid_ff + LW'(1);
   assign hi_n  = gt ? mid_ff : hi_ff;
   assign mid_n = lo_n + ((hi_n - lo_n) >> 1);

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      eq_in        = eq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = mid_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = lo_ff[AW-1:0];
      upd_len      = len_ff;
      upd_ovf      = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = req_tdata[VALUE_BITS-1:0];
               if (req_tuser) begin
                  len_in = '0;
                  ovf_in = 1'b0;
               end
               lo_in  = '0;
               hi_in  = start_len;
               mid_in = start_len >> 1;
               eq_in  = 1'b0;
               if (start_len != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = mid_in[AW-1:0];
                  state_in = ST_PROBE;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_PROBE: begin
            lo_in = lo_n;
            hi_in = hi_n;
            if (!gt) begin
               eq_in = (rd_data_ff == value_ff);
            end
            if (lo_n < hi_n) begin
               mid_in  = mid_n;
               rd_en   = 1'b1;
               rd_addr = mid_n[AW-1:0];
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!eq_ff) begin
               if (lo_ff < len_ff) begin
                  wr_en = 1'b1;
               end else if (len_ff < LW'(TABLE_DEPTH)) begin
                  wr_en   = 1'b1;
                  upd_len = len_ff + LW'(1);
               end else begin
                  upd_ovf = 1'b1;
               end
            end
            len_in = upd_len;
            ovf_in = upd_ovf;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pack_rsp(upd_len, upd_ovf);
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pack_rsp(len_ff, ovf_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff    <= value_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      eq_ff       <= eq_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tail_mem_ff[wr_addr] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= tail_mem_ff[rd_addr];
      end
   end

endmodule
